### design/vps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vps_pkg;

	// fixed field widths
	localparam int IN_W      = 24;  // force and position request fields
	localparam int DT_W      = 16;  // time step, Q0.16
	localparam int MASS_W    = 24;  // mass, Q16.8
	localparam int SIZE_W    = 12;  // area width / height, whole pixels
	localparam int RAD_W     = 8;   // radius, whole pixels
	localparam int DAMP_W    = 16;  // damping, Q0.16
	localparam int CFG_W     = 24;  // widest register
	localparam int CFG_IDX_W = 3;

	// serial arithmetic
	localparam int MUL_B_W = 32;              // multiplier bits, one per cycle
	localparam int QUO_W   = 32;              // divider quotient bits
	localparam int ACC_W   = IN_W + 2 * DT_W; // |force| * dt * dt plus rounding
	localparam int DIV_SH  = 24;              // divisor is mass * 2^24
	localparam int DAMP_SH = DAMP_W;          // damping product scale

	typedef enum logic [1:0] {
		ACT_INTEGRATE,
		ACT_CONSTRAIN,
		ACT_MOVE,
		ACT_PLACE
	} vps_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MASS,
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_PINNED,
		CFG_RADIUS,
		CFG_DAMPING
	} vps_cfg_idx_t;

	localparam logic [MASS_W-1:0] MASS_RST   = 24'd256;
	localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd800;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd600;
	localparam logic [RAD_W-1:0]  RAD_RST    = 8'd15;
	localparam logic [DAMP_W-1:0] DAMP_RST   = 16'd5898;  // 0.09

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} vps_unit_stat_t;

endpackage

`default_nettype wire

### design/vps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vps_req_if import vps_pkg::*; ();
	logic                   valid;
	logic                   ready;
	vps_action_t            action;
	logic signed [IN_W-1:0] force_x;
	logic signed [IN_W-1:0] force_y;
	logic [DT_W-1:0]        time_step;
	logic signed [IN_W-1:0] pos_x;
	logic signed [IN_W-1:0] pos_y;

	modport source (output valid, action, force_x, force_y, time_step, pos_x, pos_y,
		input ready);
	modport sink (input valid, action, force_x, force_y, time_step, pos_x, pos_y,
		output ready);
endinterface

interface vps_rsp_if #(parameter int POS_BITS = 24) ();
	logic                       valid;
	logic                       ready;
	logic signed [POS_BITS-1:0] cur_x;
	logic signed [POS_BITS-1:0] cur_y;
	logic                       wall_hit;

	modport source (output valid, cur_x, cur_y, wall_hit, input ready);
	modport sink (input valid, cur_x, cur_y, wall_hit, output ready);
endinterface

`default_nettype wire

### design/vps_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module vps_mul import vps_pkg::*; #(
	parameter int A_W = 24,
	parameter int B_W = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [A_W-1:0]       a,
	input  wire logic [B_W-1:0]       b,
	output vps_unit_stat_t            stat,
	output logic [A_W+B_W-1:0]        prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [A_W:0]       sum;

	assign sum = {1'b0, prod_q[A_W+B_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			prod_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				prod_q <= {{A_W{1'b0}}, b};
				cnt_q  <= CNT_W'(B_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {sum, prod_q[B_W-1:1]};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = prod_q;

endmodule

`default_nettype wire

### design/vps_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module vps_div import vps_pkg::*; #(
	parameter int N_W = 32,
	parameter int D_W = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [N_W-1:0] num,
	input  wire logic [D_W-1:0] den,
	output vps_unit_stat_t      stat,
	output logic [N_W-1:0]      quo
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W-1:0]   den_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q  <= den;
				rem_q  <= '0;
				quo_q  <= num;
				cnt_q  <= CNT_W'(N_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
				quo_q <= {quo_q[N_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

`default_nettype wire

### design/verlet_particle_step.sv
// Position Verlet step for one 2D particle with wall clamping.
//
// Channels: req (sink) carries one request per handshake: action, forces,
// time step and a position. rsp (source) returns one result per request:
// the current position after the action and a wall hit flag. A request is
// taken when valid and ready are both high at a rising clock edge.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the user
// must write only while the block is idle, the block itself does not enforce it.
// Path from request accepted to result registered:
//   move, place, or any pinned action: straight to S_OUT
//   constrain: two serial multiplies, one per axis, each followed by clamps
//   integrate: dt^2, then per axis a serial multiply and a serial divide
// The multiplier and divider are shared and bit-serial; one request is
// processed at a time and req.ready is high only when idle, so a new
// request is taken only after the last one has left S_OUT.
// A finished result sits in the rsp register while the next request is
// taken; if rsp is still stalled when that one finishes, it waits.
// Reset: positions go to zero, registers to their defaults, rsp empty.
`timescale 1ns / 1ps
`default_nettype none

module verlet_particle_step import vps_pkg::*; #(
	parameter int POS_BITS  = 24,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vps_req_if.sink                   req,
	vps_rsp_if.source                 rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// multiplier operand A holds dt, |force| or |cur - prev|
	localparam int MA   = (POS_BITS + 1 > IN_W) ? POS_BITS + 1 : IN_W;
	localparam int PW   = MA + MUL_B_W;
	// working width for sums ahead of saturation
	localparam int WIDE = ((POS_BITS > QUO_W) ? POS_BITS : QUO_W) + 3;
	localparam logic [PW-1:0] DAMP_HALF = PW'(1) << (DAMP_SH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TSQ,   // dt * dt
		S_FMUL,  // |force| * dt^2
		S_DIV,   // divide by mass
		S_SUM,   // verlet update of one axis
		S_DMUL,  // |cur - prev| * damping
		S_CLR,   // right / bottom wall
		S_CLL,   // left / top wall
		S_CLP,   // fix prev after a clamp
		S_OUT
	} state_t;

	state_t state_q;

	// config
	logic [MASS_W-1:0] cfg_mass_q;
	logic [SIZE_W-1:0] cfg_width_q;
	logic [SIZE_W-1:0] cfg_height_q;
	logic              cfg_pin_q;
	logic [RAD_W-1:0]  cfg_rad_q;
	logic [DAMP_W-1:0] cfg_damp_q;

	// particle state
	logic signed [POS_BITS-1:0] now_x_q, now_y_q, old_x_q, old_y_q;

	// per-request work
	logic                     axis_q;   // 0 = x, 1 = y
	logic [IN_W-1:0]          fmag_x_q, fmag_y_q;
	logic                     fneg_x_q, fneg_y_q;
	logic [MUL_B_W-1:0]       t_q;      // dt^2
	logic signed [POS_BITS+1:0] vel_q;  // damped velocity
	logic                     ax_hit_q;
	logic                     hit_q;
	vps_action_t              act_q;

	// result register
	logic                       rsp_valid_q;
	logic signed [POS_BITS-1:0] rsp_x_q, rsp_y_q;
	logic                       rsp_hit_q;

	// serial units
	logic               mul_start;
	logic [MA-1:0]      mul_a;
	logic [MUL_B_W-1:0] mul_b;
	vps_unit_stat_t     mul_stat;
	logic [PW-1:0]      mul_prod;
	logic               div_start;
	logic [QUO_W-1:0]   div_num;
	vps_unit_stat_t     div_stat;
	logic [QUO_W-1:0]   div_quo;

	logic accept;
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// result register takes a new value when empty or being drained
	logic rsp_load;
	assign rsp_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [WIDE-1:0] v);
		logic [WIDE-POS_BITS:0] hi_bits;
		hi_bits = v[WIDE-1:POS_BITS-1];
		if (hi_bits == '0 || hi_bits == '1)
			return $signed(v[POS_BITS-1:0]);
		else if (v[WIDE-1])
			return $signed({1'b1, {(POS_BITS-1){1'b0}}});
		else
			return $signed({1'b0, {(POS_BITS-1){1'b1}}});
	endfunction

	// force magnitudes at the request boundary
	logic [IN_W-1:0] fx_neg, fy_neg;
	assign fx_neg = '0 - req.force_x;
	assign fy_neg = '0 - req.force_y;

	// mass 0 divides as 1
	logic [MASS_W-1:0] m_eff;
	assign m_eff = (cfg_mass_q == '0) ? MASS_W'(1) : cfg_mass_q;

	// axis under work
	logic signed [POS_BITS-1:0] now_sel, old_sel;
	logic [SIZE_W-1:0]          size_sel;
	logic                       fneg_sel;
	assign now_sel  = axis_q ? now_y_q : now_x_q;
	assign old_sel  = axis_q ? old_y_q : old_x_q;
	assign size_sel = axis_q ? cfg_height_q : cfg_width_q;
	assign fneg_sel = axis_q ? fneg_y_q : fneg_x_q;

	logic signed [WIDE-1:0] now_w, old_w, vel_w, r_w, s_w, q_w, term_w;
	assign now_w  = {{(WIDE-POS_BITS){now_sel[POS_BITS-1]}}, now_sel};
	assign old_w  = {{(WIDE-POS_BITS){old_sel[POS_BITS-1]}}, old_sel};
	assign vel_w  = {{(WIDE-POS_BITS-2){vel_q[POS_BITS+1]}}, vel_q};
	assign r_w    = $signed(WIDE'(cfg_rad_q) << FRAC_BITS);
	assign s_w    = $signed(WIDE'(size_sel) << FRAC_BITS);
	assign q_w    = $signed({{(WIDE-QUO_W){1'b0}}, div_quo});
	assign term_w = fneg_sel ? -q_w : q_w;

	logic signed [POS_BITS-1:0] int_val, right_val, left_val, prev_val;
	logic                       right_hit, left_hit;
	assign int_val   = sat_pos((now_w <<< 1) - old_w + term_w);
	assign right_hit = (now_w + r_w) > s_w;
	assign right_val = sat_pos(s_w - r_w);
	assign left_hit  = now_w < r_w;
	assign left_val  = sat_pos(r_w);
	assign prev_val  = sat_pos(now_w + vel_w);

	// velocity magnitude source; in S_CLP the y axis is set up next
	logic                       dm_idx;
	logic signed [POS_BITS-1:0] dm_now, dm_old;
	logic signed [POS_BITS:0]   dm_diff, dm_neg;
	logic [POS_BITS:0]          dm_mag;
	assign dm_idx  = (state_q == S_CLP) ? 1'b1 : axis_q;
	assign dm_now  = dm_idx ? now_y_q : now_x_q;
	assign dm_old  = dm_idx ? old_y_q : old_x_q;
	assign dm_diff = {dm_now[POS_BITS-1], dm_now} - {dm_old[POS_BITS-1], dm_old};
	assign dm_neg  = -dm_diff;
	assign dm_mag  = dm_diff[POS_BITS] ? dm_neg : dm_diff;

	// rounded products
	logic [ACC_W-1:0]         acc_num;
	logic [PW-1:0]            vel_round;
	logic [POS_BITS:0]        vel_mag;
	logic signed [POS_BITS+1:0] vel_pos;
	assign acc_num   = mul_prod[ACC_W-1:0] + ACC_W'({m_eff, {(DIV_SH-1){1'b0}}});
	assign vel_round = mul_prod + DAMP_HALF;
	assign vel_mag   = vel_round[DAMP_SH +: POS_BITS+1];
	assign vel_pos   = $signed({1'b0, vel_mag});

	// unit launches
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = acc_num[ACC_W-1:DIV_SH];
		unique case (state_q)
			S_IDLE: begin
				if (accept && !cfg_pin_q && req.action == ACT_INTEGRATE) begin
					mul_start = 1'b1;
					mul_a     = MA'(req.time_step);
					mul_b     = MUL_B_W'(req.time_step);
				end else if (accept && !cfg_pin_q && req.action == ACT_CONSTRAIN) begin
					mul_start = 1'b1;
					mul_a     = MA'(dm_mag);
					mul_b     = MUL_B_W'(cfg_damp_q);
				end
			end
			S_TSQ: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = MA'(fmag_x_q);
					mul_b     = mul_prod[MUL_B_W-1:0];
				end
			end
			S_FMUL: div_start = mul_stat.done;
			S_SUM: begin
				if (!axis_q) begin
					mul_start = 1'b1;
					mul_a     = MA'(fmag_y_q);
					mul_b     = t_q;
				end
			end
			S_CLP: begin
				if (!axis_q) begin
					mul_start = 1'b1;
					mul_a     = MA'(dm_mag);
					mul_b     = MUL_B_W'(cfg_damp_q);
				end
			end
			default: ;
		endcase
	end

	vps_mul #(.A_W(MA), .B_W(MUL_B_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	vps_div #(.N_W(QUO_W), .D_W(MASS_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (m_eff),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mass_q   <= MASS_RST;
			cfg_width_q  <= WIDTH_RST;
			cfg_height_q <= HEIGHT_RST;
			cfg_pin_q    <= 1'b0;
			cfg_rad_q    <= RAD_RST;
			cfg_damp_q   <= DAMP_RST;
		end else if (cfg_we) begin
			unique case (vps_cfg_idx_t'(cfg_index))
				CFG_MASS:    cfg_mass_q   <= cfg_data[MASS_W-1:0];
				CFG_WIDTH:   cfg_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT:  cfg_height_q <= cfg_data[SIZE_W-1:0];
				CFG_PINNED:  cfg_pin_q    <= cfg_data[0];
				CFG_RADIUS:  cfg_rad_q    <= cfg_data[RAD_W-1:0];
				CFG_DAMPING: cfg_damp_q   <= cfg_data[DAMP_W-1:0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// sequencer, particle state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_x_q     <= '0;
			now_y_q     <= '0;
			old_x_q     <= '0;
			old_y_q     <= '0;
			axis_q      <= 1'b0;
			fmag_x_q    <= '0;
			fmag_y_q    <= '0;
			fneg_x_q    <= 1'b0;
			fneg_y_q    <= 1'b0;
			t_q         <= '0;
			vel_q       <= '0;
			ax_hit_q    <= 1'b0;
			hit_q       <= 1'b0;
			act_q       <= ACT_INTEGRATE;
			rsp_valid_q <= 1'b0;
			rsp_x_q     <= '0;
			rsp_y_q     <= '0;
			rsp_hit_q   <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q    <= req.action;
						hit_q    <= 1'b0;
						fmag_x_q <= req.force_x[IN_W-1] ? fx_neg : req.force_x;
						fmag_y_q <= req.force_y[IN_W-1] ? fy_neg : req.force_y;
						fneg_x_q <= req.force_x[IN_W-1];
						fneg_y_q <= req.force_y[IN_W-1];
						unique case (req.action)
							ACT_INTEGRATE: state_q <= cfg_pin_q ? S_OUT : S_TSQ;
							ACT_CONSTRAIN: state_q <= cfg_pin_q ? S_OUT : S_DMUL;
							ACT_MOVE: begin
								now_x_q <= sat_pos({{(WIDE-IN_W){req.pos_x[IN_W-1]}}, req.pos_x});
								now_y_q <= sat_pos({{(WIDE-IN_W){req.pos_y[IN_W-1]}}, req.pos_y});
								state_q <= S_OUT;
							end
							ACT_PLACE: begin
								now_x_q <= sat_pos({{(WIDE-IN_W){req.pos_x[IN_W-1]}}, req.pos_x});
								now_y_q <= sat_pos({{(WIDE-IN_W){req.pos_y[IN_W-1]}}, req.pos_y});
								old_x_q <= sat_pos({{(WIDE-IN_W){req.pos_x[IN_W-1]}}, req.pos_x});
								old_y_q <= sat_pos({{(WIDE-IN_W){req.pos_y[IN_W-1]}}, req.pos_y});
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_TSQ: begin
					if (mul_stat.done) begin
						t_q     <= mul_prod[MUL_B_W-1:0];
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					if (mul_stat.done)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done)
						state_q <= S_SUM;
				end
				S_SUM: begin
					// axes are independent: commit this one now
					if (axis_q) begin
						old_y_q <= now_y_q;
						now_y_q <= int_val;
						state_q <= S_OUT;
					end else begin
						old_x_q <= now_x_q;
						now_x_q <= int_val;
						axis_q  <= 1'b1;
						state_q <= S_FMUL;
					end
				end
				S_DMUL: begin
					if (mul_stat.done) begin
						vel_q    <= dm_diff[POS_BITS] ? -vel_pos : vel_pos;
						ax_hit_q <= 1'b0;
						state_q  <= S_CLR;
					end
				end
				S_CLR: begin
					if (right_hit) begin
						if (axis_q) now_y_q <= right_val;
						else        now_x_q <= right_val;
						ax_hit_q <= 1'b1;
					end
					state_q <= S_CLL;
				end
				S_CLL: begin
					// checked on the value left by the right / bottom clamp
					if (left_hit) begin
						if (axis_q) now_y_q <= left_val;
						else        now_x_q <= left_val;
						ax_hit_q <= 1'b1;
					end
					state_q <= S_CLP;
				end
				S_CLP: begin
					// prev follows the final clamp target plus damped velocity
					if (ax_hit_q) begin
						if (axis_q) old_y_q <= prev_val;
						else        old_x_q <= prev_val;
					end
					hit_q <= hit_q | ax_hit_q;
					if (axis_q) begin
						state_q <= S_OUT;
					end else begin
						axis_q  <= 1'b1;
						state_q <= S_DMUL;
					end
				end
				S_OUT: begin
					if (rsp_load) begin
						rsp_x_q     <= now_x_q;
						rsp_y_q     <= now_y_q;
						rsp_hit_q   <= hit_q;
						axis_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.cur_x    = rsp_x_q;
	assign rsp.cur_y    = rsp_y_q;
	assign rsp.wall_hit = rsp_hit_q;

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier launched while busy");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider launched while busy");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!mul_stat.busy && !div_stat.busy && !axis_q))
		else $error("ready while arithmetic still running");

	a_pinned_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cfg_pin_q && (req.action == ACT_INTEGRATE || req.action == ACT_CONSTRAIN))
		|=> (now_x_q == $past(now_x_q) && now_y_q == $past(now_y_q)))
		else $error("pinned particle moved");

	a_hit_constrain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && hit_q) |-> (act_q == ACT_CONSTRAIN))
		else $error("wall hit outside a constrain request");

endmodule

`default_nettype wire

### dv/tb_verlet_particle_step.sv
`timescale 1ns / 1ps

// Testbench for the particle step block: directed corners first, then long runs of
// place / integrate / constrain sequences under random settings.
module tb_verlet_particle_step import vps_pkg::*; ();

	localparam int POS_BITS  = 24;
	localparam int FRAC_BITS = 8;
	localparam int RAND_ITEMS = 1900;
	localparam int PHASES     = 8;

	localparam longint POS_HI = (longint'(1) <<< (POS_BITS - 1)) - 1;
	localparam longint POS_LO = -POS_HI - 1;

	localparam logic signed [IN_W-1:0] IN_HI = {1'b0, {(IN_W-1){1'b1}}};
	localparam logic signed [IN_W-1:0] IN_LO = {1'b1, {(IN_W-1){1'b0}}};
	localparam logic [DT_W-1:0]        DT_HI = {DT_W{1'b1}};

	// indexes past the last register: writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(int'(CFG_DAMPING) + 1);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(int'(CFG_DAMPING) + 2);

	typedef struct {
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic                       hit;
	} particle_pos_t;

	typedef struct {
		logic [MASS_W-1:0] mass;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic              pinned;
		logic [RAD_W-1:0]  radius;
		logic [DAMP_W-1:0] damp;
	} particle_cfg_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	vps_req_if req_ch ();
	vps_rsp_if #(.POS_BITS(POS_BITS)) rsp_ch ();

	verlet_particle_step #(
		.POS_BITS (POS_BITS),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow of the particle: positions and register settings as the block should hold them.
	logic signed [POS_BITS-1:0] pos_cur_x, pos_cur_y, pos_prev_x, pos_prev_y;
	particle_cfg_t              cfg_now;

	particle_pos_t expected_pos[$];   // one entry per accepted request, oldest first
	int            mismatches   = 0;
	int            requests_sent = 0;
	bit            idle_on      = 1'b1; // cleared for back-to-back stretches on both sides

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run (all integrates, longest gaps and stalls)
	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Fixed-point model of one step
	// ------------------------------------------------------------------

	function automatic longint clip_pos(input longint v);
		if (v > POS_HI) return POS_HI;
		if (v < POS_LO) return POS_LO;
		return v;
	endfunction

	function automatic longint unsigned abs_val(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// force * dt^2 / (mass * 2^24), magnitude rounded half away from zero.
	// Zero mass acts as the smallest divisor.
	function automatic longint force_offset(input logic signed [IN_W-1:0] f,
		input logic [DT_W-1:0] dt);
		longint unsigned div, prod, quo;
		div  = ((cfg_now.mass == '0) ? 64'd1 : 64'(cfg_now.mass)) << DIV_SH;
		prod = abs_val(longint'(f)) * dt * dt;
		quo  = (prod + div / 2) / div;
		return (f < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	// velocity scaled by the damping factor, Q0.16, same rounding
	function automatic longint damped_vel(input longint v);
		longint unsigned prod;
		prod = abs_val(v) * cfg_now.damp;
		prod = (prod + (64'd1 << (DAMP_SH - 1))) >> DAMP_SH;
		return (v < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// Far wall first, then near wall. When the area is narrower than the
	// particle both fire and the near wall wins.
	function automatic bit wall_clamp(inout longint cur, inout longint prev, input longint vel,
		input logic [SIZE_W-1:0] size);
		longint rad, span;
		bit     hit;
		rad  = longint'(cfg_now.radius) <<< FRAC_BITS;
		span = longint'(size) <<< FRAC_BITS;
		hit  = 1'b0;
		if (cur + rad > span) begin
			cur  = clip_pos(span - rad);
			prev = clip_pos(cur + vel);
			hit  = 1'b1;
		end
		if (cur - rad < 0) begin
			cur  = clip_pos(rad);
			prev = clip_pos(cur + vel);
			hit  = 1'b1;
		end
		return hit;
	endfunction

	// Apply one request to the shadow particle, return what the block must report.
	function automatic particle_pos_t advance_particle(input vps_action_t act,
		input logic signed [IN_W-1:0] fx, fy, input logic [DT_W-1:0] dt,
		input logic signed [IN_W-1:0] px, py);
		longint        cx, cy, ox, oy, nx, ny, vx, vy;
		bit            hx, hy;
		particle_pos_t res;
		cx = pos_cur_x;
		cy = pos_cur_y;
		ox = pos_prev_x;
		oy = pos_prev_y;
		hx = 1'b0;
		hy = 1'b0;
		case (act)
			ACT_INTEGRATE: begin
				if (!cfg_now.pinned) begin
					nx = clip_pos(2 * cx - ox + force_offset(fx, dt));
					ny = clip_pos(2 * cy - oy + force_offset(fy, dt));
					ox = cx;
					oy = cy;
					cx = nx;
					cy = ny;
				end
			end
			ACT_CONSTRAIN: begin
				if (!cfg_now.pinned) begin
					// both velocities are taken before either axis is clamped
					vx = damped_vel(cx - ox);
					vy = damped_vel(cy - oy);
					hx = wall_clamp(cx, ox, vx, cfg_now.width);
					hy = wall_clamp(cy, oy, vy, cfg_now.height);
				end
			end
			ACT_MOVE: begin
				cx = px;
				cy = py;
			end
			default: begin
				cx = px;
				cy = py;
				ox = px;
				oy = py;
			end
		endcase
		pos_cur_x  = cx[POS_BITS-1:0];
		pos_cur_y  = cy[POS_BITS-1:0];
		pos_prev_x = ox[POS_BITS-1:0];
		pos_prev_y = oy[POS_BITS-1:0];
		res.x   = pos_cur_x;
		res.y   = pos_cur_y;
		res.hit = hx | hy;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic signed [IN_W-1:0] rand_word();
		return IN_W'($urandom);
	endfunction

	// signed force spread over many magnitudes
	function automatic logic signed [IN_W-1:0] rand_force();
		logic signed [IN_W-1:0] f;
		f = IN_W'($urandom);
		return f >>> $urandom_range(0, 14);
	endfunction

	function automatic logic [DT_W-1:0] rand_dt();
		logic [DT_W-1:0] dt;
		dt = DT_W'($urandom);
		return dt >> $urandom_range(0, 8);
	endfunction

	function automatic logic signed [IN_W-1:0] pixels_q(input int p);
		return IN_W'(p * (1 << FRAC_BITS));
	endfunction

	// a point on one axis between 0 and the area size
	function automatic logic signed [IN_W-1:0] spot_in(input logic [SIZE_W-1:0] size);
		return IN_W'($urandom_range(0, int'(size) << FRAC_BITS));
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {SIZE_W{1'b1}};
			default: return SIZE_W'($urandom_range(40, 1600));
		endcase
	endfunction

	function automatic particle_cfg_t random_settings();
		particle_cfg_t c;
		case ($urandom_range(0, 5))
			0: c.mass = '0;
			1: c.mass = MASS_W'(1);
			2: c.mass = {MASS_W{1'b1}};
			default: c.mass = MASS_W'($urandom_range(16, 2048));
		endcase
		c.width  = rand_size();
		c.height = rand_size();
		c.pinned = ($urandom_range(0, 7) == 0);
		case ($urandom_range(0, 9))
			0: c.radius = {RAD_W{1'b1}};
			1: c.radius = '0;
			default: c.radius = RAD_W'($urandom_range(1, 40));
		endcase
		case ($urandom_range(0, 7))
			0: c.damp = '0;
			1: c.damp = {DAMP_W{1'b1}};
			default: c.damp = DAMP_W'($urandom);
		endcase
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Request side and register port
	// ------------------------------------------------------------------

	// Called right after a rising edge. Valid stays high after the handshake;
	// the next call either keeps it up with new fields or drops it for a gap.
	task automatic send_request(input vps_action_t act, input logic signed [IN_W-1:0] fx, fy,
		input logic [DT_W-1:0] dt, input logic signed [IN_W-1:0] px, py);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.force_x   <= fx;
		req_ch.force_y   <= fy;
		req_ch.time_step <= dt;
		req_ch.pos_x     <= px;
		req_ch.pos_y     <= py;
		do @(posedge clk); while (!req_ch.ready);
		expected_pos.push_back(advance_particle(act, fx, fy, dt, px, py));
		requests_sent++;
	endtask

	// drop valid and wait for every outstanding result; the block is idle after
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_pos.size() != 0);
	endtask

	// one register write; the caller lowers the write enable after the last one
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_MASS:    cfg_now.mass   = data[MASS_W-1:0];
			CFG_WIDTH:   cfg_now.width  = data[SIZE_W-1:0];
			CFG_HEIGHT:  cfg_now.height = data[SIZE_W-1:0];
			CFG_PINNED:  cfg_now.pinned = data[0];
			CFG_RADIUS:  cfg_now.radius = data[RAD_W-1:0];
			CFG_DAMPING: cfg_now.damp   = data[DAMP_W-1:0];
			default: ;
		endcase
	endtask

	// Writes every register, plus the two spare indexes. With junk set, the bits
	// above each register's width carry noise that must be dropped.
	task automatic apply_settings(input particle_cfg_t c, input bit junk);
		logic [CFG_W-1:0] fill;
		fill = '0;
		if (junk) fill = CFG_W'($urandom);
		put_reg(CFG_MASS, c.mass);
		put_reg(CFG_WIDTH, {fill[CFG_W-1:SIZE_W], c.width});
		put_reg(CFG_HEIGHT, {fill[CFG_W-1:SIZE_W], c.height});
		put_reg(CFG_PINNED, {fill[CFG_W-1:1], c.pinned});
		put_reg(CFG_RADIUS, {fill[CFG_W-1:RAD_W], c.radius});
		put_reg(CFG_DAMPING, {fill[CFG_W-1:DAMP_W], c.damp});
		put_reg(CFG_SPARE_A, CFG_W'($urandom));
		put_reg(CFG_SPARE_B, CFG_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random backpressure and in-order comparison
	// ------------------------------------------------------------------

	initial begin : result_check
		particle_pos_t want;
		int            stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (expected_pos.size() == 0) begin
					$error("result with no request outstanding: cur_x %0d cur_y %0d",
						rsp_ch.cur_x, rsp_ch.cur_y);
					mismatches++;
				end else begin
					want = expected_pos.pop_front();
					if (rsp_ch.cur_x !== want.x) begin
						$error("cur_x: expected %0d, actual %0d", want.x, rsp_ch.cur_x);
						mismatches++;
					end
					if (rsp_ch.cur_y !== want.y) begin
						$error("cur_y: expected %0d, actual %0d", want.y, rsp_ch.cur_y);
						mismatches++;
					end
					if (rsp_ch.wall_hit !== want.hit) begin
						$error("wall_hit: expected %0b, actual %0b", want.hit, rsp_ch.wall_hit);
						mismatches++;
					end
				end
			end
			if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 15)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings (800 x 600 area, radius 15, mass 1.0, damping 0.09).
	task automatic test_corners();
		// after reset the particle sits at the origin, inside left and top walls
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(400), pixels_q(300));
		// largest push and time step: positions run into saturation
		send_request(ACT_INTEGRATE, IN_HI, IN_LO, DT_HI, '0, '0);
		// right and top clamps, huge velocity through the damping
		send_request(ACT_CONSTRAIN, IN_LO, IN_HI, DT_HI, IN_LO, IN_HI);
		// coasting on the velocity alone, then a push that rounds to nothing
		send_request(ACT_INTEGRATE, '0, '0, '0, IN_HI, IN_LO);
		send_request(ACT_INTEGRATE, -24'sd1, 24'sd1, 16'd1, '0, '0);
		// move to both corners of the position range
		send_request(ACT_MOVE, IN_HI, IN_HI, DT_HI, IN_HI, IN_LO);
		send_request(ACT_MOVE, IN_LO, IN_LO, '0, IN_LO, IN_HI);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		// two full pushes from rest: the second overshoots and saturates
		send_request(ACT_PLACE, '0, '0, '0, '0, '0);
		send_request(ACT_INTEGRATE, IN_HI, IN_HI, DT_HI, '0, '0);
		send_request(ACT_INTEGRATE, IN_HI, IN_HI, DT_HI, '0, '0);
		// exact half-unit acceleration term: rounds away from zero on both signs
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(200), pixels_q(200));
		send_request(ACT_INTEGRATE, 24'sd128, -24'sd128, 16'd4096, '0, '0);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		// resting right on the left and bottom walls: no hit
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(15), pixels_q(585));
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		// one LSB past both walls
		send_request(ACT_MOVE, '0, '0, '0, pixels_q(15) - 24'sd1, pixels_q(585) + 24'sd1);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
	endtask

	// pinned: integrate and constrain leave the particle alone, move and place still act
	task automatic test_pinned();
		particle_cfg_t c;
		wait_idle();
		c        = cfg_now;
		c.pinned = 1'b1;
		apply_settings(c, 1'b0);
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(900), pixels_q(-50));
		send_request(ACT_MOVE, '0, '0, '0, pixels_q(1000), pixels_q(700));
		send_request(ACT_INTEGRATE, IN_HI, IN_LO, DT_HI, '0, '0);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		wait_idle();
		c.pinned = 1'b0;
		apply_settings(c, 1'b1);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
	endtask

	// Area narrower than the particle (both clamps on an axis fire), then the
	// widest area with zero radius.
	task automatic test_narrow_area();
		particle_cfg_t c;
		wait_idle();
		c        = cfg_now;
		c.width  = SIZE_W'(10);
		c.height = '0;
		c.radius = {RAD_W{1'b1}};
		apply_settings(c, 1'b0);
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(5), '0);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		wait_idle();
		c.width  = {SIZE_W{1'b1}};
		c.height = {SIZE_W{1'b1}};
		c.radius = '0;
		c.damp   = {DAMP_W{1'b1}};
		apply_settings(c, 1'b1);
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(4095), '0);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		send_request(ACT_MOVE, '0, '0, '0, pixels_q(4095) + 24'sd1, -24'sd1);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
	endtask

	// zero mass with full damping, then the heaviest mass with no damping
	task automatic test_setting_extremes();
		particle_cfg_t c;
		wait_idle();
		c        = cfg_now;
		c.mass   = '0;
		c.width  = SIZE_W'(800);
		c.height = SIZE_W'(600);
		c.radius = RAD_W'(15);
		c.damp   = {DAMP_W{1'b1}};
		apply_settings(c, 1'b0);
		send_request(ACT_PLACE, '0, '0, '0, pixels_q(100), pixels_q(100));
		send_request(ACT_INTEGRATE, 24'sd256, -24'sd256, DT_HI, '0, '0);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
		wait_idle();
		c.mass = {MASS_W{1'b1}};
		c.damp = '0;
		apply_settings(c, 1'b0);
		send_request(ACT_INTEGRATE, IN_HI, IN_LO, DT_HI, '0, '0);
		send_request(ACT_CONSTRAIN, '0, '0, '0, '0, '0);
	endtask

	// One particle's life: dropped inside the area, then frames of integrate and
	// constrain with an occasional drag, sprinkled with fully random requests.
	task automatic fly_particle();
		int                     frames, r;
		logic signed [IN_W-1:0] pull_y;
		idle_on = ($urandom_range(0, 9) != 0);
		frames  = $urandom_range(2, 24);
		pull_y  = rand_force();
		send_request(ACT_PLACE, rand_word(), rand_word(), DT_W'($urandom),
			spot_in(cfg_now.width), spot_in(cfg_now.height));
		repeat (frames) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_request(vps_action_t'($urandom_range(0, 3)), rand_word(), rand_word(),
					DT_W'($urandom), rand_word(), rand_word());
			end else if (r < 14) begin
				send_request(ACT_MOVE, rand_word(), rand_word(), DT_W'($urandom),
					spot_in(cfg_now.width), spot_in(cfg_now.height));
			end else begin
				send_request(ACT_INTEGRATE, rand_force(), pull_y, rand_dt(),
					rand_word(), rand_word());
				if (r < 90)
					send_request(ACT_CONSTRAIN, rand_word(), rand_word(), DT_W'($urandom),
						rand_word(), rand_word());
			end
		end
	endtask

	// Settings change between phases; the first two phases take the top and
	// bottom corners of every register but the pin flag, which stays clear.
	task automatic test_random_motion();
		particle_cfg_t c;
		int            target;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			c = random_settings();
			if (phase == 0) begin
				c = '{{MASS_W{1'b1}}, {SIZE_W{1'b1}}, {SIZE_W{1'b1}}, 1'b0,
					{RAD_W{1'b1}}, {DAMP_W{1'b1}}};
			end else if (phase == 1) begin
				c = '{'0, '0, '0, 1'b0, '0, '0};
			end
			apply_settings(c, 1'($urandom_range(0, 1)));
			target = requests_sent + RAND_ITEMS / PHASES;
			while (requests_sent < target)
				fly_particle();
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.action    = ACT_INTEGRATE;
		req_ch.force_x   = '0;
		req_ch.force_y   = '0;
		req_ch.time_step = '0;
		req_ch.pos_x     = '0;
		req_ch.pos_y     = '0;
		cfg_now          = '{MASS_RST, WIDTH_RST, HEIGHT_RST, 1'b0, RAD_RST, DAMP_RST};
		pos_cur_x        = '0;
		pos_cur_y        = '0;
		pos_prev_x       = '0;
		pos_prev_y       = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_pinned();
		test_narrow_area();
		test_setting_extremes();
		test_random_motion();

		// drain, then leave room for any stray result to show up
		wait_idle();
		repeat (200) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
